// ----- hdl/ebs_pkg.sv -----
// Shared types, constants and sizes for the embedding-bag sum block.
package ebs_pkg;

  // Sizing
  localparam int TABLE_ROWS   = 1024;
  localparam int MAX_COLS     = 16;
  localparam int ACC_WIDTH    = 48;

  localparam int TABLE_DEPTH  = TABLE_ROWS * MAX_COLS;
  localparam int ADDR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CIDX_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Fixed field widths
  localparam int CMD_W        = 2;
  localparam int ROW_W        = 10;
  localparam int COL_W        = 4;
  localparam int WORD_W       = 32;
  localparam int NUM_COLS_W   = 5;
  localparam int SUM_W        = 48;

  localparam int NUM_COLS_RST = 16;

  // Item command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Input item
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         word_col;
    logic signed [WORD_W-1:0] table_value;
    logic                     end_of_bag;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [COL_W-1:0]        out_col;
    logic signed [SUM_W-1:0] col_sum;
    logic                    last_col;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              wr_en;   // store table word from the input item
    logic              ld_row;  // capture row of an add item
    logic              rd_en;   // read table word for column col
    logic              emit;    // present accumulator col as a result
    logic              last;    // this is the final column of the bag
    logic              clear;   // zero all accumulators
    logic [CIDX_W-1:0] col;
  } ctl_t;

endpackage

// ----- hdl/ebs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ebs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ebs_ctrl.sv -----
// Controller: item decode, column sequencing and the column-count register.
module ebs_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  ebs_pkg::in_item_t                in_i,
  input  logic                             cfg_we_i,
  input  logic [ebs_pkg::NUM_COLS_W-1:0]   cfg_wdata_i,
  output ebs_pkg::ctl_t                    ctl_o
);
  import ebs_pkg::*;

  state_e            state_q, state_d;
  logic [CIDX_W-1:0] col_q, col_d;
  logic              eob_q, eob_d;
  logic [NUM_COLS_W-1:0] num_cols_q;
  logic [CIDX_W-1:0] last_idx;
  logic              accept;
  logic              row_ok;
  logic              col_ok;

  // Column-count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NUM_COLS_W'(NUM_COLS_RST);
    end else if (cfg_we_i) begin
      num_cols_q <= cfg_wdata_i;
    end
  end

  // Index of the last used column: zero acts as one, large values clamp
  always_comb begin
    if (num_cols_q == '0) begin
      last_idx = '0;
    end else if (32'(num_cols_q) > MAX_COLS) begin
      last_idx = CIDX_W'(MAX_COLS - 1);
    end else begin
      last_idx = CIDX_W'(num_cols_q - NUM_COLS_W'(1));
    end
  end

  assign accept = start && !busy;
  assign row_ok = 32'(in_i.row_index) < TABLE_ROWS;
  assign col_ok = 32'(in_i.word_col) < MAX_COLS;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      eob_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      eob_q   <= eob_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    eob_d        = eob_q;
    busy         = (state_q != ST_IDLE);
    ctl_o        = '0;
    ctl_o.col    = col_q;

    unique case (state_q)
      ST_IDLE: begin
        col_d = '0;
        if (accept) begin
          unique case (in_i.cmd)
            CMD_WRITE: begin
              ctl_o.wr_en = row_ok && col_ok;
            end
            CMD_ADD: begin
              eob_d        = in_i.end_of_bag;
              ctl_o.ld_row = 1'b1;
              if (row_ok) begin
                state_d = ST_READ;
              end else if (in_i.end_of_bag) begin
                state_d = ST_EMIT;
              end
            end
            CMD_EMPTY: begin
              state_d = ST_EMIT;
            end
            default: begin
              // reserved code: no effect
            end
          endcase
        end
      end

      // One table read per column
      ST_READ: begin
        ctl_o.rd_en = 1'b1;
        if (col_q == last_idx) begin
          col_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          col_d = col_q + CIDX_W'(1);
        end
      end

      // Last accumulate lands here
      ST_DRAIN: begin
        state_d = eob_q ? ST_EMIT : ST_IDLE;
      end

      // One result per column, then clear
      ST_EMIT: begin
        ctl_o.emit = 1'b1;
        if (col_q == last_idx) begin
          ctl_o.last  = 1'b1;
          ctl_o.clear = 1'b1;
          col_d       = '0;
          state_d     = ST_IDLE;
        end else begin
          col_d = col_q + CIDX_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ebs_datapath.sv -----
// Datapath: table memory, saturating column accumulators and result register.
module ebs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ebs_pkg::in_item_t  in_i,
  input  ebs_pkg::ctl_t      ctl_i,
  output logic               res_strobe_o,
  output ebs_pkg::out_item_t res_o
);
  import ebs_pkg::*;

  localparam logic signed [ACC_WIDTH:0] ACC_MAX = (ACC_WIDTH+1)'((64'd1 << (ACC_WIDTH-1)) - 64'd1);
  localparam logic signed [ACC_WIDTH:0] ACC_MIN = -ACC_MAX - (ACC_WIDTH+1)'(1);

  logic [ROW_W-1:0]               row_q;
  logic [ADDR_W-1:0]              waddr;
  logic [ADDR_W-1:0]              raddr;
  logic [WORD_W-1:0]              rdata;
  logic                           acc_en_q;
  logic [CIDX_W-1:0]              acc_col_q;
  logic signed [ACC_WIDTH-1:0]    acc_q [MAX_COLS];
  logic signed [ACC_WIDTH:0]      sum_wide;
  logic signed [ACC_WIDTH-1:0]    sum_sat;
  logic signed [63:0]             emit_ext;
  logic                           strobe_q;
  out_item_t                      res_q;

  // Row of the current add item
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_row) begin
      row_q <= in_i.row_index;
    end
  end

  // Table addressing: row-major, MAX_COLS words per row
  assign waddr = ADDR_W'(ADDR_W'(in_i.row_index) * ADDR_W'(MAX_COLS)
                 + ADDR_W'(in_i.word_col));
  assign raddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(ctl_i.col));

  ebs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (in_i.table_value),
    .re_i    (ctl_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read data is registered, so it is valid in the cycle after the read command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= ctl_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_col_q <= ctl_i.col;
  end

  // Saturating add of one table word
  always_comb begin
    sum_wide = (ACC_WIDTH+1)'(acc_q[acc_col_q]) + (ACC_WIDTH+1)'(signed'(rdata));
    if (sum_wide > ACC_MAX) begin
      sum_sat = ACC_WIDTH'(ACC_MAX);
    end else if (sum_wide < ACC_MIN) begin
      sum_sat = ACC_WIDTH'(ACC_MIN);
    end else begin
      sum_sat = ACC_WIDTH'(sum_wide);
    end
  end

  // Column accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctl_i.clear) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (acc_en_q) begin
      acc_q[acc_col_q] <= sum_sat;
    end
  end

  // Result register: sign-extend, then keep the low result bits
  assign emit_ext = 64'(acc_q[ctl_i.col]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_q.out_col  <= COL_W'(ctl_i.col);
      res_q.col_sum  <= emit_ext[SUM_W-1:0];
      res_q.last_col <= ctl_i.last;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ----- hdl/embedding_bag_sum_core.sv -----
// Top level of the embedding-bag sum block.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   input    | start, busy            | in_i (cmd, row, col, word, eob)
//   result   | res_strobe_o           | res_o (out_col, col_sum, last_col)
//   config   | cfg_we_i               | cfg_wdata_i (num_cols)
//
// With n used columns: a write item leaves busy low; an add item holds busy
// for one table read per column through the single read port, then for the
// last accumulate; closing a bag emits one result per column, each strobed in
// the cycle after its emit cycle.
// Reset clears the accumulators and sets num_cols to 16, not the table. Results
// cannot be stalled; an item is taken when start is high and busy is low.
module embedding_bag_sum_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ebs_pkg::in_item_t              in_i,
  input  logic                           cfg_we_i,
  input  logic [ebs_pkg::NUM_COLS_W-1:0] cfg_wdata_i,
  output logic                           res_strobe_o,
  output ebs_pkg::out_item_t             res_o
);
  import ebs_pkg::*;

  ctl_t ctl;

  ebs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_o       (ctl)
  );

  ebs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .ctl_i        (ctl),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule
